// ===== design/vmed_pkg.sv =====
// ---------------------------------------------------------------------------
// vmed_pkg: shared types and constants for the vector median block
// Row capacity, field widths and the controller/datapath command bundles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vmed_pkg;

    // Row capacity and derived widths
    localparam int MAX_LEN  = 64;
    localparam int FILL_W   = $clog2(MAX_LEN + 1);
    localparam int SAMPLE_W = 32;
    localparam int MED_W    = SAMPLE_W + 1;
    localparam int LEN_W    = 7;

    typedef logic [FILL_W-1:0] fill_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic insert;   // take one sample word into the row
        logic shift;    // move the row one place toward entry zero
        logic emit;     // load the result register and start a new vector
    } vmed_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        fill_t fill;    // entries held for the current vector
    } vmed_status_t;

endpackage

`default_nettype wire

// ===== design/vector_median.sv =====
// ---------------------------------------------------------------------------
// vector_median: streaming median of one vector of samples
// Sorted insertion row with a controller that walks to the middle entry.
// ---------------------------------------------------------------------------
// Usage:
//   Send the samples of a vector on the s_ channel, one word per cycle, with
//   s_last_sample high on the final one. Samples are signed Q16.16. Each
//   vector gives one word on the m_ channel: the median in signed Q16.17,
//   the number of samples kept and an overflow flag.
//   Within a vector a sample is taken every cycle: each one is placed into
//   a sorted row of MAX_LEN registers by a parallel compare. Samples past
//   MAX_LEN are dropped and flag overflow; the vector is still closed.
//   After the last sample s_ready drops while the controller loads the walk
//   count, shifts the row toward its first entry until the lower middle
//   entry is there, and loads the result register once it is free.
//   The result appears on the cycle after that. The shift through the row,
//   and a result still waiting on m_ready, set this gap.
//   A result waiting on m_ready does not block the next vector's samples;
//   only the hand-off of the following result waits for the register.
//   Reset (aresetn low, synchronous) empties the row and drops any result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vector_median
    import vmed_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic signed [SAMPLE_W-1:0] s_sample,
    input  wire logic                       s_last_sample,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    output logic signed [MED_W-1:0]         m_median_value,
    output logic [LEN_W-1:0]                m_vector_length,
    output logic                            m_overflow,
    output logic                            m_valid,
    input  wire logic                       m_ready
);

    vmed_cmd_t    cmd;
    vmed_status_t status;

    vmed_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_last_sample (s_last_sample),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .status        (status),
        .cmd           (cmd)
    );

    vmed_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_sample        (s_sample),
        .cmd             (cmd),
        .status          (status),
        .m_median_value  (m_median_value),
        .m_vector_length (m_vector_length),
        .m_overflow      (m_overflow)
    );

    // Closing a vector stops intake until the result is loaded into the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_sample) |=> !s_ready)
        else $error("intake not stopped after last sample");

    // A result always carries at least one kept sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_vector_length != '0))
        else $error("result with empty vector");

    // Dropping samples only happens with a full row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overflow) |-> (m_vector_length == LEN_W'(MAX_LEN)))
        else $error("overflow flagged with row not full");

    // A new result is loaded only when the previous one is gone or leaving
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");

endmodule

`default_nettype wire

// ===== design/vmed_ctrl.sv =====
// ---------------------------------------------------------------------------
// vmed_ctrl: sequencer for the vector median block
// Accepts sample words, walks the sorted row to its middle and hands off
// the result to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmed_ctrl
    import vmed_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    input  wire logic         s_last_sample,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  vmed_status_t      status,
    output vmed_cmd_t         cmd
);

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_LOAD   = 2'd1;
    localparam logic [1:0] ST_SHIFT  = 2'd2;

    logic [1:0] state_reg, state_next;
    fill_t      cnt_reg, cnt_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;
    logic       out_free;

    assign s_ready  = (state_reg == ST_ACCEPT);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Decode state into datapath commands
    always_comb begin
        cmd.insert = accept;
        cmd.shift  = (state_reg == ST_SHIFT) && (cnt_reg != '0);
        cmd.emit   = (state_reg == ST_SHIFT) && (cnt_reg == '0) && out_free;
    end

    // Next state, shift count and result valid
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_ACCEPT: begin
                if (accept && s_last_sample) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // Shifts needed to bring the lower middle entry to place zero
                cnt_next   = (status.fill - fill_t'(1)) >> 1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - fill_t'(1);
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_ACCEPT;
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCEPT;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/vmed_datapath.sv =====
// ---------------------------------------------------------------------------
// vmed_datapath: sorted register row and median result register
// Parallel-compare insertion keeps the row ascending; a shift walks it to
// the middle, and the result is formed from the lowest entry, or the two lowest.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmed_datapath
    import vmed_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic signed [SAMPLE_W-1:0] s_sample,
    input  vmed_cmd_t                       cmd,
    output vmed_status_t                    status,
    output logic signed [MED_W-1:0]         m_median_value,
    output logic [LEN_W-1:0]                m_vector_length,
    output logic                            m_overflow
);

    logic signed [SAMPLE_W-1:0] row_reg  [MAX_LEN];
    logic signed [SAMPLE_W-1:0] row_next [MAX_LEN];
    logic [MAX_LEN-1:0]         greater;
    fill_t                      fill_reg, fill_next;
    logic                       ovf_reg, ovf_next;
    logic                       has_room;
    logic                       row_en;
    logic signed [MED_W-1:0]    med_reg, med_next;
    logic [LEN_W-1:0]           len_reg;
    logic                       ovf_out_reg;

    assign has_room    = (fill_reg < fill_t'(MAX_LEN));
    assign status.fill = fill_reg;
    assign row_en      = cmd.shift || (cmd.insert && has_room);

    // Per-cell insert or shift
    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        logic take_prev;
        logic place_here;
        logic signed [SAMPLE_W-1:0] prev_val;
        logic signed [SAMPLE_W-1:0] shift_in;

        assign greater[i] = (fill_t'(i) < fill_reg) && (row_reg[i] > s_sample);

        // The first cell has no neighbor below it
        if (i == 0) begin : g_first
            assign take_prev = 1'b0;
            assign prev_val  = row_reg[i];
        end else begin : g_rest
            assign take_prev = greater[i-1];
            assign prev_val  = row_reg[i-1];
        end

        if (i == MAX_LEN - 1) begin : g_end
            assign shift_in = row_reg[i];
        end else begin : g_mid
            assign shift_in = row_reg[i+1];
        end

        assign place_here = greater[i] || (fill_t'(i) == fill_reg);

        assign row_next[i] = cmd.shift  ? shift_in :
                             take_prev  ? prev_val :
                             place_here ? s_sample : row_reg[i];
    end

    // Hold or update the row
    always_ff @(posedge aclk) begin
        if (row_en) begin
            for (int i = 0; i < MAX_LEN; i++) begin
                row_reg[i] <= row_next[i];
            end
        end
    end

    // Fill count and sticky drop flag
    always_comb begin
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        if (cmd.emit) begin
            fill_next = '0;
            ovf_next  = 1'b0;
        end else if (cmd.insert) begin
            if (has_room) begin
                fill_next = fill_reg + fill_t'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
        end
    end

    // Odd length: twice the middle entry; even: sum of the two middle entries
    always_comb begin
        if (fill_reg[0]) begin
            med_next = {row_reg[0], 1'b0};
        end else begin
            med_next = MED_W'(row_reg[0]) + MED_W'(row_reg[1]);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            med_reg     <= med_next;
            len_reg     <= LEN_W'(fill_reg);
            ovf_out_reg <= ovf_reg;
        end
    end

    assign m_median_value  = med_reg;
    assign m_vector_length = len_reg;
    assign m_overflow      = ovf_out_reg;

endmodule

`default_nettype wire
